/* rtl/utf8sv_pkg.sv */
package utf8sv_pkg;

  // Widths fixed by the field definitions
  localparam int DATA_W    = 8;
  localparam int MAX_LEN_W = 13;
  localparam int CP_W      = 21;
  localparam int APB_DW    = 32;
  localparam int PADDR_W   = 3;
  localparam int TDATA_W   = 8;

  // Defaults
  localparam int                   DEF_LENGTH_CAP = 4096;
  localparam logic [MAX_LEN_W-1:0] MAX_LENGTH_RST = 13'd4096;

  // Register word index
  localparam logic REG_MAX_LENGTH = 1'b0;

  // Sequence size classes
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_TWO  = 2'd1;
  localparam logic [1:0] CLS_THREE = 2'd2;
  localparam logic [1:0] CLS_FOUR = 2'd3;

  // Lead byte ranges
  localparam logic [DATA_W-1:0] ASCII_TOP = 8'h80;
  localparam logic [DATA_W-1:0] LEAD2_LO  = 8'hC2;
  localparam logic [DATA_W-1:0] LEAD2_HI  = 8'hDF;
  localparam logic [DATA_W-1:0] LEAD3_LO  = 8'hE0;
  localparam logic [DATA_W-1:0] LEAD3_HI  = 8'hEF;
  localparam logic [DATA_W-1:0] LEAD4_LO  = 8'hF0;
  localparam logic [DATA_W-1:0] LEAD4_HI  = 8'hF4;
  localparam logic [1:0]        CONT_TAG  = 2'b10;

  // Code point limits
  localparam logic [CP_W-1:0] CP_MIN2  = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN3  = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN4  = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;

  // One byte beat held in the input register
  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] data;
    logic              last;
  } beat_t;

  // Verdict handed to the output register
  typedef struct packed {
    logic vld;
    logic ok;
  } verdict_t;

  // Smallest code point a sequence of the given class may encode
  function automatic logic [CP_W-1:0] class_min(input logic [1:0] cls);
    logic [CP_W-1:0] m;
    unique case (cls)
      CLS_TWO:   m = CP_MIN2;
      CLS_THREE: m = CP_MIN3;
      default:   m = CP_MIN4;
    endcase
    return m;
  endfunction

endpackage

/* rtl/utf8sv_cfg.sv */
module utf8sv_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [utf8sv_pkg::PADDR_W-1:0]      paddr,
  input  logic [utf8sv_pkg::APB_DW-1:0]       pwdata,
  output logic [utf8sv_pkg::APB_DW-1:0]       prdata,
  output logic                                pready,
  output logic [utf8sv_pkg::MAX_LEN_W-1:0]    max_length
);
  import utf8sv_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write the length limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RST;
    end else if (wr_en && (paddr[PADDR_W-1] == REG_MAX_LENGTH)) begin
      max_length <= pwdata[MAX_LEN_W-1:0];
    end
  end

  // Read back
  always_comb begin
    if (paddr[PADDR_W-1] == REG_MAX_LENGTH) begin
      prdata = APB_DW'(max_length);
    end else begin
      prdata = '0;
    end
  end

endmodule

/* rtl/utf8sv_in_reg.sv */
module utf8sv_in_reg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [utf8sv_pkg::DATA_W-1:0]   s_tdata,
  input  logic                            s_tlast,
  input  logic                            take,
  output utf8sv_pkg::beat_t               beat
);
  import utf8sv_pkg::*;

  // Accept a beat when empty or when the held beat moves on this cycle
  assign s_tready = !beat.vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      beat.vld <= 1'b1;
    end else if (take) begin
      beat.vld <= 1'b0;
    end
  end

  // Hold the payload until the next beat is accepted
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      beat.data <= s_tdata;
      beat.last <= s_tlast;
    end
  end

endmodule

/* rtl/utf8sv_core.sv */
module utf8sv_core #(
  parameter int LENGTH_CAP = utf8sv_pkg::DEF_LENGTH_CAP
) (
  input  logic                              clk,
  input  logic                              rst,
  input  utf8sv_pkg::beat_t                 beat,
  input  logic                              out_free,
  input  logic [utf8sv_pkg::MAX_LEN_W-1:0]  max_length,
  output logic                              take,
  output utf8sv_pkg::verdict_t              verdict,
  output logic                              idle_state
);
  import utf8sv_pkg::*;

  localparam int CW = $clog2(LENGTH_CAP + 2);
  localparam int LW = (CW > MAX_LEN_W) ? CW : MAX_LEN_W;
  localparam logic [CW-1:0] CNT_SAT = CW'(LENGTH_CAP + 1);
  localparam logic [LW-1:0] CAP_L   = LW'(LENGTH_CAP);

  logic [CP_W-1:0] acc, acc_next;
  logic [1:0]      tails, tails_next;
  logic [1:0]      cls, cls_next;
  logic            err, err_next;
  logic [CW-1:0]   count, count_next;
  logic [CP_W-1:0] cp;
  logic [LW-1:0]   limit;
  logic [LW-1:0]   ml_l;

  // A final byte waits for room in the output register
  assign take = beat.vld && (!beat.last || out_free);

  // Clamp the configured limit to the counter cap
  assign ml_l  = LW'(max_length);
  assign limit = (ml_l > CAP_L) ? CAP_L : ml_l;

  // Decode one byte
  always_comb begin
    acc_next   = acc;
    tails_next = tails;
    cls_next   = cls;
    err_next   = err;
    cp         = {acc[CP_W-7:0], beat.data[5:0]};
    count_next = (count < CNT_SAT) ? count + 1'b1 : count;

    if (tails == 2'd0) begin
      priority if (beat.data == '0) begin
        err_next = 1'b1;
      end else if (beat.data < ASCII_TOP) begin
        err_next = err;
      end else if (beat.data >= LEAD2_LO && beat.data <= LEAD2_HI) begin
        tails_next = 2'd1;
        cls_next   = CLS_TWO;
        acc_next   = CP_W'(beat.data[4:0]);
      end else if (beat.data >= LEAD3_LO && beat.data <= LEAD3_HI) begin
        tails_next = 2'd2;
        cls_next   = CLS_THREE;
        acc_next   = CP_W'(beat.data[3:0]);
      end else if (beat.data >= LEAD4_LO && beat.data <= LEAD4_HI) begin
        tails_next = 2'd3;
        cls_next   = CLS_FOUR;
        acc_next   = CP_W'(beat.data[2:0]);
      end else begin
        err_next = 1'b1;
      end
    end else begin
      if (beat.data[7:6] != CONT_TAG) begin
        err_next = 1'b1;
      end
      acc_next   = cp;
      tails_next = tails - 2'd1;
      // Check the finished code point
      if (tails == 2'd1) begin
        if (cp < class_min(cls) || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
          err_next = 1'b1;
        end
        acc_next = '0;
        cls_next = CLS_NONE;
      end
    end
  end

  // Give the verdict on the final byte
  always_comb begin
    verdict.vld = take && beat.last;
    verdict.ok  = !err_next && (tails_next == 2'd0) && (LW'(count_next) <= limit);
  end

  // Advance the string state; clear it after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      tails <= 2'd0;
      cls   <= CLS_NONE;
      err   <= 1'b0;
      count <= '0;
    end else if (take) begin
      if (beat.last) begin
        acc   <= '0;
        tails <= 2'd0;
        cls   <= CLS_NONE;
        err   <= 1'b0;
        count <= '0;
      end else begin
        acc   <= acc_next;
        tails <= tails_next;
        cls   <= cls_next;
        err   <= err_next;
        count <= count_next;
      end
    end
  end

  assign idle_state = (tails == 2'd0) && (count == '0) && !err && (acc == '0);

endmodule

/* rtl/utf8sv_out_reg.sv */
module utf8sv_out_reg (
  input  logic                            clk,
  input  logic                            rst,
  input  utf8sv_pkg::verdict_t            verdict,
  output logic                            out_free,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [utf8sv_pkg::TDATA_W-1:0]  m_tdata
);
  import utf8sv_pkg::*;

  logic ok;

  assign out_free = !m_tvalid || m_tready;

  // Hold the verdict until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (verdict.vld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.vld) begin
      ok <= verdict.ok;
    end
  end

  assign m_tdata = TDATA_W'(ok);

endmodule

/* rtl/utf8_stream_validator.sv */
// The final byte passes through the input register, then the verdict register, before
//   the verdict beat is valid.
// Throughput: one byte per cycle while no final byte waits, set by the single-pass decoder update that closes on
//   its own state registers between the input register and the verdict register.
// A final byte waits in the input register while an earlier verdict is not yet taken.
// Reset (rst, synchronous, active high) empties both registers, clears the string state
//   and sets max_length to 4096.
module utf8_stream_validator #(
  parameter int LENGTH_CAP = utf8sv_pkg::DEF_LENGTH_CAP
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [utf8sv_pkg::PADDR_W-1:0]     paddr,
  input  logic [utf8sv_pkg::APB_DW-1:0]      pwdata,
  output logic [utf8sv_pkg::APB_DW-1:0]      prdata,
  output logic                               pready,
  // Byte stream in
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [utf8sv_pkg::DATA_W-1:0]      s_tdata,   // [7:0] data_byte
  input  logic                               s_tlast,   // last_byte
  // Verdict out
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [utf8sv_pkg::TDATA_W-1:0]     m_tdata    // [0] valid_res, [7:1] zero
);
  import utf8sv_pkg::*;

  logic [MAX_LEN_W-1:0] max_length;
  beat_t                beat;
  verdict_t             verdict;
  logic                 take;
  logic                 out_free;
  logic                 idle_state;

  utf8sv_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_length (max_length)
  );

  utf8sv_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .take     (take),
    .beat     (beat)
  );

  utf8sv_core #(
    .LENGTH_CAP (LENGTH_CAP)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .beat       (beat),
    .out_free   (out_free),
    .max_length (max_length),
    .take       (take),
    .verdict    (verdict),
    .idle_state (idle_state)
  );

  utf8sv_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .verdict  (verdict),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A final byte always yields a verdict beat next cycle
  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    take && beat.last |=> m_tvalid)
    else $error("final byte gave no verdict");

  // String state is clear after a final byte
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    take && beat.last |=> idle_state)
    else $error("string state not cleared after final byte");

  // A verdict never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    verdict.vld |-> (!m_tvalid || m_tready))
    else $error("verdict overwrote a pending beat");

  // A held byte stays put while it cannot move on
  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    beat.vld && !take |=> beat.vld && $stable(beat.data) && $stable(beat.last))
    else $error("held byte lost or changed");

endmodule
